/* rtl/tga_pkg.sv */
// tga_pkg: shared types, constants and helpers of the TGA RLE decoder.
// Used by tga_front, tga_jobq, tga_back and tga_rle_decoder; no dependencies.
package tga_pkg;

	localparam int MAX_CHUNK_BYTES = 4;
	localparam int ADDRESS_BITS    = 26;
	localparam int RUN_BIAS        = 127;
	localparam int JOBQ_DEPTH      = 4;
	localparam int JOBQ_PTR_BITS   = $clog2(JOBQ_DEPTH);

	// output tdata layout, lowest field first
	localparam int OUT_ADDR_LSB  = 0;
	localparam int OUT_VALUE_LSB = ADDRESS_BITS;
	localparam int OUT_COUNT_LSB = ADDRESS_BITS + 32;
	localparam int OUT_BITS      = ADDRESS_BITS + 32 + 8;
	localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_CHUNK_BYTES = 2'd0,
		REG_ROW_CHUNKS  = 2'd1,
		REG_ROW_PITCH   = 2'd2,
		REG_ROW_COUNT   = 2'd3
	} reg_idx_t;

	// effective (saturated) configuration
	typedef struct packed {
		logic [2:0]  chunk_bytes;
		logic [12:0] row_chunks;
		logic [14:0] row_pitch;
		logic [12:0] row_count;
	} cfg_t;

	// one chunk handed from the parser to the segment writer
	typedef struct packed {
		logic [31:0] value;
		logic [7:0]  count;
	} job_t;

	function automatic logic [2:0] sat_chunk_bytes(input logic [2:0] raw);
		logic [2:0] r;
		r = raw;
		if (raw == 3'd0)
			r = 3'd1;
		else if (raw > 3'(MAX_CHUNK_BYTES))
			r = 3'(MAX_CHUNK_BYTES);
		return r;
	endfunction

	function automatic logic [12:0] sat_row_chunks(input logic [12:0] raw);
		logic [12:0] r;
		r = raw;
		if (raw < 13'd4)
			r = 13'd4;
		else if (raw > 13'd4096)
			r = 13'd4096;
		return r;
	endfunction

	function automatic logic [12:0] sat_row_count(input logic [12:0] raw);
		logic [12:0] r;
		r = raw;
		if (raw == 13'd0)
			r = 13'd1;
		else if (raw > 13'd4096)
			r = 13'd4096;
		return r;
	endfunction

endpackage

/* rtl/tga_front.sv */
// tga_front: packet header parser and chunk gatherer; pushes one job per chunk.
// Depends on tga_pkg.
module tga_front (
	input  logic             clk,
	input  logic             arst_n,
	input  tga_pkg::cfg_t    cfg,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] data_byte
	input  logic             q_full,
	output logic             q_push,
	output tga_pkg::job_t    q_job
);
	import tga_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_REPEAT  = 3'b010,
		PH_LITERAL = 3'b100
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  left_q, left_d;
	logic [1:0]  bic_q, bic_d;
	logic [31:0] gather_q, gather_d;
	logic [31:0] gather_n;
	logic [7:0]  left_after;
	logic        take;

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;
	assign gather_n = gather_q | (32'(s_tdata) << {bic_q, 3'b000});

	always_comb begin
		phase_d    = phase_q;
		left_d     = left_q;
		bic_d      = bic_q;
		gather_d   = gather_q;
		q_push     = 1'b0;
		q_job      = '{value: gather_n, count: 8'd1};
		left_after = left_q - 8'd1;
		if (take) begin
			case (phase_q)
				PH_REPEAT, PH_LITERAL: begin
					if (({1'b0, bic_q} + 3'd1) < cfg.chunk_bytes) begin
						bic_d    = bic_q + 2'd1;
						gather_d = gather_n;
					end else begin
						q_push   = 1'b1;
						bic_d    = 2'd0;
						gather_d = '0;
						if (phase_q == PH_REPEAT) begin
							q_job.count = left_q;
							left_after  = 8'd0;
						end
						left_d = left_after;
						if (left_after == 8'd0)
							phase_d = PH_HEADER;
					end
				end
				default: begin
					if (s_tdata[7]) begin
						left_d  = s_tdata - 8'(RUN_BIAS);
						phase_d = PH_REPEAT;
					end else begin
						left_d  = s_tdata + 8'd1;
						phase_d = PH_LITERAL;
					end
					bic_d    = 2'd0;
					gather_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			left_q   <= '0;
			bic_q    <= '0;
			gather_q <= '0;
		end else begin
			phase_q  <= phase_d;
			left_q   <= left_d;
			bic_q    <= bic_d;
			gather_q <= gather_d;
		end
	end

endmodule

/* rtl/tga_jobq.sv */
// tga_jobq: small FIFO of chunk jobs between parser and segment writer.
// Depends on tga_pkg.
module tga_jobq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tga_pkg::job_t    push_job,
	input  logic             pop,
	output tga_pkg::job_t    head_job,
	output logic             empty,
	output logic             full
);
	import tga_pkg::*;

	job_t                     mem_q [JOBQ_DEPTH];
	logic [JOBQ_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [JOBQ_PTR_BITS:0]   cnt_q;
	logic                     do_push, do_pop;

	assign empty    = (cnt_q == '0);
	assign full     = (cnt_q == (JOBQ_PTR_BITS+1)'(JOBQ_DEPTH));
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* rtl/tga_back.sv */
// tga_back: splits chunk jobs into row-bounded write segments, tracks rows.
// Depends on tga_pkg.
module tga_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tga_pkg::cfg_t               cfg,
	input  tga_pkg::job_t               head_job,
	input  logic                        head_valid,
	output logic                        pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [tga_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                        m_tlast,
	output logic                        m_tuser
);
	import tga_pkg::*;

	logic                    part_q;
	logic [7:0]              left_q;
	logic [11:0]             column_q;
	logic [ADDRESS_BITS-1:0] base_q;
	logic [11:0]             rows_q;
	logic                    fin_q;

	logic                    ovalid_q;
	logic [ADDRESS_BITS-1:0] oaddr_q;
	logic [31:0]             ovalue_q;
	logic [7:0]              ocount_q;
	logic                    odone_q, olast_q;

	logic [7:0]              n;
	logic [12:0]             col13, room, newcol, next_row;
	logic [7:0]              seg;
	logic [14:0]             col_off;
	logic [ADDRESS_BITS-1:0] seg_addr;
	logic                    out_free, emit, row_end, finishing, job_end;

	always_comb begin
		n        = part_q ? left_q : head_job.count;
		col13    = {1'b0, column_q};
		room     = (col13 < cfg.row_chunks) ? (cfg.row_chunks - col13) : 13'd1;
		seg      = ({5'b0, n} < room) ? n : room[7:0];
		newcol   = col13 + {5'b0, seg};
		row_end  = (newcol >= cfg.row_chunks);
		next_row = {1'b0, rows_q} + 13'd1;
		finishing = row_end && (next_row >= cfg.row_count);
		job_end  = (seg == n) || finishing;
		col_off  = {3'b0, column_q} * {12'b0, cfg.chunk_bytes};
		seg_addr = base_q + {{(ADDRESS_BITS-15){1'b0}}, col_off};
		out_free = !ovalid_q || m_tready;
		emit     = head_valid && !fin_q && out_free;
		// after the image is done, queued jobs are drained and dropped
		pop      = head_valid && (fin_q || (out_free && job_end));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q   <= 1'b0;
			column_q <= '0;
			base_q   <= '0;
			rows_q   <= '0;
			fin_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_free)
				ovalid_q <= emit;
			if (emit) begin
				part_q <= !job_end;
				if (row_end) begin
					column_q <= '0;
					base_q   <= base_q + {{(ADDRESS_BITS-15){1'b0}}, cfg.row_pitch};
					if (finishing)
						fin_q <= 1'b1;
					else
						rows_q <= next_row[11:0];
				end else begin
					column_q <= newcol[11:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			left_q   <= n - seg;
			oaddr_q  <= seg_addr;
			ovalue_q <= head_job.value;
			ocount_q <= seg;
			odone_q  <= finishing;
			olast_q  <= job_end;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, ocount_q, ovalue_q, oaddr_q};
	assign m_tlast  = olast_q;
	assign m_tuser  = odone_q;

endmodule

/* rtl/tga_rle_decoder.sv */
// tga_rle_decoder: TGA RLE stream decoder producing row-bounded write segments.
// A byte that completes a chunk is queued, then registered as its first segment.
// Throughput: one input byte per cycle unless the job queue is full; one segment per
// cycle while m_tready allows, and a repeat run is split into one segment per row.
// Reset (arst_n low, async): registers back to defaults, parser awaits a header,
// row/column tracking cleared, job queue emptied. No clearing pass.
module tga_rle_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [tga_pkg::OUT_TDATA_W-1:0] m_tdata, // write_address, chunk_value,
	                                                 // chunk_count, zero pad
	output logic        m_tlast,   // last
	output logic        m_tuser    // image_done
);
	import tga_pkg::*;

	logic [2:0]  chunk_bytes_q;
	logic [12:0] row_chunks_q;
	logic [14:0] row_pitch_q;
	logic [12:0] row_count_q;
	cfg_t        cfg;

	logic        q_push, q_pop, q_empty, q_full;
	job_t        q_job, head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_bytes_q <= 3'd1;
			row_chunks_q  <= 13'd4;
			row_pitch_q   <= 15'd4;
			row_count_q   <= 13'd1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_CHUNK_BYTES: chunk_bytes_q <= cfg_data[2:0];
				REG_ROW_CHUNKS:  row_chunks_q  <= cfg_data[12:0];
				REG_ROW_PITCH:   row_pitch_q   <= cfg_data;
				REG_ROW_COUNT:   row_count_q   <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	assign cfg = '{
		chunk_bytes: sat_chunk_bytes(chunk_bytes_q),
		row_chunks:  sat_row_chunks(row_chunks_q),
		row_pitch:   row_pitch_q,
		row_count:   sat_row_count(row_count_q)
	};

	tga_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (q_job)
	);

	tga_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.pop      (q_pop),
		.head_job (head_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	tga_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_job   (head_job),
		.head_valid (!q_empty),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

`ifndef SYNTHESIS
	// the segment that fills the last row always closes its item
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("image_done segment without last");

	// nothing follows once the image is done
	a_quiet_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tuser) |=> !m_tvalid)
		else $error("segment after image done");

	// parser never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job queue overflow");

	// every segment writes at least one chunk
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_COUNT_LSB +: 8] != 8'd0))
		else $error("empty segment");
`endif

endmodule
